[hw/rtl/adf_pkg.sv]
// Package for the ADC distance decimal formatter.
// Holds field widths, register indexes, ASCII codes and divide-by-ten helpers.
// No dependencies; every other file of the block uses it.
package adf_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 13;
    localparam int NUM_W    = 16;
    localparam int DEN_W    = 16;
    localparam int DIST_W   = 29;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 2;
    localparam int BCD_W    = 14;
    localparam int DIGIT_W  = 4;

    // Depth of the pipeline: the offset add register, the multiply register, one divider
    // stage per quotient bit, and the decimal digit stages.
    localparam int LATENCY = 2 + DIST_W + 3;

    localparam logic [IDX_W-1:0] REG_SAMPLE_OFFSET     = 2'd0;
    localparam logic [IDX_W-1:0] REG_SCALE_NUMERATOR   = 2'd1;
    localparam logic [IDX_W-1:0] REG_SCALE_DENOMINATOR = 2'd2;

    localparam logic [SAMPLE_W-1:0] RST_SAMPLE_OFFSET     = 12'd2;
    localparam logic [NUM_W-1:0]    RST_SCALE_NUMERATOR   = 16'd2000;
    localparam logic [DEN_W-1:0]    RST_SCALE_DENOMINATOR = 16'd4094;

    localparam logic [DIST_W-1:0] DISPLAY_MAX = 29'd9999;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_STAR  = 8'h2A;
    localparam logic [7:0] ASCII_POINT = 8'h2E;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_C     = 8'h63;
    localparam logic [7:0] ASCII_M     = 8'h6D;

    // Reciprocal of ten scaled by 2^19, exact for every 14-bit value.
    localparam logic [15:0] RECIP_TEN = 16'd52429;

    typedef struct packed {
        logic [DIGIT_W-1:0] units;
        logic [DIGIT_W-1:0] tenths;
        logic [DIGIT_W-1:0] hundredths;
        logic [DIGIT_W-1:0] thousandths;
    } t_digits;

    function automatic logic [BCD_W-1:0] f_div10(input logic [BCD_W-1:0] v);
        logic [BCD_W+15:0] p;
        p = (BCD_W+16)'(v) * (BCD_W+16)'(RECIP_TEN);
        return BCD_W'(p[BCD_W+15:19]);
    endfunction

    function automatic logic [DIGIT_W-1:0] f_rem10(input logic [BCD_W-1:0] v,
                                                    input logic [BCD_W-1:0] q);
        logic [BCD_W-1:0] t;
        t = v - ((q << 3) + (q << 1));
        return t[DIGIT_W-1:0];
    endfunction

endpackage

[hw/rtl/adf_scale.sv]
// Offset and scale front end: adds the offset, then multiplies by the numerator.
// Two register stages with a valid bit; depends on adf_pkg.
module adf_scale (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [adf_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [adf_pkg::SAMPLE_W-1:0] i_offset,
    input  logic [adf_pkg::NUM_W-1:0]    i_numerator,
    output logic                         o_valid,
    output logic [adf_pkg::DIST_W-1:0]   o_product
);

    logic                         r_sum_vld;
    logic [adf_pkg::SUM_W-1:0]    r_sum;
    logic                         r_prod_vld;
    logic [adf_pkg::DIST_W-1:0]   r_prod;
    logic [adf_pkg::SUM_W-1:0]    n_sum;
    logic [adf_pkg::DIST_W-1:0]   n_prod;

    assign n_sum  = adf_pkg::SUM_W'(i_sample) + adf_pkg::SUM_W'(i_offset);
    assign n_prod = adf_pkg::DIST_W'(r_sum) * adf_pkg::DIST_W'(i_numerator);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld  <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_sum_vld  <= i_valid;
            r_prod_vld <= r_sum_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_prod <= n_prod;
    end

    assign o_valid   = r_prod_vld;
    assign o_product = r_prod;

endmodule

[hw/rtl/adf_divider.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// A zero divisor yields an all-ones quotient; depends on adf_pkg.
module adf_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [adf_pkg::DIST_W-1:0] i_dividend,
    input  logic [adf_pkg::DEN_W-1:0]  i_divisor,
    output logic                       o_valid,
    output logic [adf_pkg::DIST_W-1:0] o_quotient
);

    localparam int STAGES = adf_pkg::DIST_W;

    logic                       r_vld [STAGES];
    logic [adf_pkg::DEN_W-1:0]  r_rem [STAGES];
    logic [adf_pkg::DIST_W-1:0] r_quo [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic                       vld_in;
        logic [adf_pkg::DEN_W-1:0]  rem_in;
        logic [adf_pkg::DIST_W-1:0] quo_in;
        logic [adf_pkg::DEN_W:0]    trial;
        logic [adf_pkg::DEN_W:0]    diff;
        logic                       take;
        logic [adf_pkg::DEN_W-1:0]  n_rem;
        logic [adf_pkg::DIST_W-1:0] n_quo;

        if (s == 0) begin : g_first
            assign vld_in = i_valid;
            assign rem_in = '0;
            assign quo_in = i_dividend;
        end else begin : g_next
            assign vld_in = r_vld[s-1];
            assign rem_in = r_rem[s-1];
            assign quo_in = r_quo[s-1];
        end

        assign trial = {rem_in, quo_in[adf_pkg::DIST_W-1]};
        assign diff  = trial - {1'b0, i_divisor};
        assign take  = (trial >= {1'b0, i_divisor});
        assign n_rem = take ? diff[adf_pkg::DEN_W-1:0] : trial[adf_pkg::DEN_W-1:0];
        assign n_quo = {quo_in[adf_pkg::DIST_W-2:0], take};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s] <= n_rem;
            r_quo[s] <= n_quo;
        end
    end

    assign o_valid    = r_vld[STAGES-1];
    assign o_quotient = r_quo[STAGES-1];

endmodule

[hw/rtl/adf_bcd.sv]
// Range check and decimal digit extraction in three register stages; each stage
// peels one digit off with a reciprocal multiply, the last stage two; depends on adf_pkg.
module adf_bcd (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [adf_pkg::DIST_W-1:0] i_dist,
    output logic                       o_valid,
    output logic [adf_pkg::DIST_W-1:0] o_dist,
    output logic                       o_ovf,
    output adf_pkg::t_digits           o_digits
);

    logic                        r_a_vld, r_b_vld, r_c_vld;
    logic [adf_pkg::DIST_W-1:0]  r_a_dist, r_b_dist, r_c_dist;
    logic                        r_a_ovf, r_b_ovf, r_c_ovf;
    logic [adf_pkg::BCD_W-1:0]   r_a_q, r_b_q;
    logic [adf_pkg::DIGIT_W-1:0] r_a_th, r_b_th, r_b_hu;
    adf_pkg::t_digits            r_c_dig;

    logic [adf_pkg::BCD_W-1:0]   n_a_v, n_a_q, n_b_q, n_c_q;

    assign n_a_v = i_dist[adf_pkg::BCD_W-1:0];
    assign n_a_q = adf_pkg::f_div10(n_a_v);
    assign n_b_q = adf_pkg::f_div10(r_a_q);
    assign n_c_q = adf_pkg::f_div10(r_b_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_dist <= i_dist;
        r_a_ovf  <= (i_dist > adf_pkg::DISPLAY_MAX);
        r_a_q    <= n_a_q;
        r_a_th   <= adf_pkg::f_rem10(n_a_v, n_a_q);

        r_b_dist <= r_a_dist;
        r_b_ovf  <= r_a_ovf;
        r_b_q    <= n_b_q;
        r_b_th   <= r_a_th;
        r_b_hu   <= adf_pkg::f_rem10(r_a_q, n_b_q);

        r_c_dist                <= r_b_dist;
        r_c_ovf                 <= r_b_ovf;
        r_c_dig.thousandths     <= r_b_th;
        r_c_dig.hundredths      <= r_b_hu;
        r_c_dig.tenths          <= adf_pkg::f_rem10(r_b_q, n_c_q);
        r_c_dig.units           <= n_c_q[adf_pkg::DIGIT_W-1:0];
    end

    assign o_valid  = r_c_vld;
    assign o_dist   = r_c_dist;
    assign o_ovf    = r_c_ovf;
    assign o_digits = r_c_dig;

endmodule

[hw/rtl/adc_distance_decimal_formatter_core.sv]
// Top level of the ADC distance decimal formatter: calibration registers,
// scale front end, pipelined divider and decimal stage; depends on adf_pkg.
//
//   Channel   Direction  Handshake                 Payload
//   command   in         start high, busy low      i_adc_sample
//   result    out        o_done, one cycle         o_distance_value, o_overflow, o_char_*
//   config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One transaction is accepted every clock cycle; busy is high only during reset.
// A result strobes o_done once its command has passed the offset add, the multiply,
// the one-bit-per-stage divider and the digit stages.
// Reset clears every valid bit, so transactions in flight are dropped.
// The receiver cannot stall; results leave the pipeline on the cycle they finish.
module adc_distance_decimal_formatter_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [adf_pkg::SAMPLE_W-1:0] i_adc_sample,
    input  logic                         i_cfg_we,
    input  logic [adf_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [adf_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                         o_done,
    output logic [adf_pkg::DIST_W-1:0]   o_distance_value,
    output logic                         o_overflow,
    output logic [7:0]                   o_char_units,
    output logic [7:0]                   o_char_point,
    output logic [7:0]                   o_char_tenths,
    output logic [7:0]                   o_char_hundredths,
    output logic [7:0]                   o_char_thousandths,
    output logic [7:0]                   o_char_space,
    output logic [7:0]                   o_char_unit_c,
    output logic [7:0]                   o_char_unit_m
);

    logic [adf_pkg::SAMPLE_W-1:0] r_sample_offset;
    logic [adf_pkg::NUM_W-1:0]    r_scale_numerator;
    logic [adf_pkg::DEN_W-1:0]    r_scale_denominator;

    logic                         accept;
    logic                         prod_vld;
    logic [adf_pkg::DIST_W-1:0]   prod;
    logic                         quo_vld;
    logic [adf_pkg::DIST_W-1:0]   quo;
    logic                         out_vld;
    logic [adf_pkg::DIST_W-1:0]   out_dist;
    logic                         out_ovf;
    adf_pkg::t_digits             out_dig;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_offset     <= adf_pkg::RST_SAMPLE_OFFSET;
            r_scale_numerator   <= adf_pkg::RST_SCALE_NUMERATOR;
            r_scale_denominator <= adf_pkg::RST_SCALE_DENOMINATOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                adf_pkg::REG_SAMPLE_OFFSET: begin
                    r_sample_offset <= i_cfg_data[adf_pkg::SAMPLE_W-1:0];
                end
                adf_pkg::REG_SCALE_NUMERATOR: begin
                    r_scale_numerator <= i_cfg_data[adf_pkg::NUM_W-1:0];
                end
                adf_pkg::REG_SCALE_DENOMINATOR: begin
                    r_scale_denominator <= i_cfg_data[adf_pkg::DEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    adf_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_sample    (i_adc_sample),
        .i_offset    (r_sample_offset),
        .i_numerator (r_scale_numerator),
        .o_valid     (prod_vld),
        .o_product   (prod)
    );

    adf_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (prod_vld),
        .i_dividend (prod),
        .i_divisor  (r_scale_denominator),
        .o_valid    (quo_vld),
        .o_quotient (quo)
    );

    adf_bcd u_bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (quo_vld),
        .i_dist   (quo),
        .o_valid  (out_vld),
        .o_dist   (out_dist),
        .o_ovf    (out_ovf),
        .o_digits (out_dig)
    );

    assign o_done             = out_vld;
    assign o_distance_value   = out_dist;
    assign o_overflow         = out_ovf;
    assign o_char_units       = out_ovf ? adf_pkg::ASCII_STAR
                                        : adf_pkg::ASCII_ZERO + 8'(out_dig.units);
    assign o_char_tenths      = out_ovf ? adf_pkg::ASCII_STAR
                                        : adf_pkg::ASCII_ZERO + 8'(out_dig.tenths);
    assign o_char_hundredths  = out_ovf ? adf_pkg::ASCII_STAR
                                        : adf_pkg::ASCII_ZERO + 8'(out_dig.hundredths);
    assign o_char_thousandths = out_ovf ? adf_pkg::ASCII_STAR
                                        : adf_pkg::ASCII_ZERO + 8'(out_dig.thousandths);
    assign o_char_point       = adf_pkg::ASCII_POINT;
    assign o_char_space       = adf_pkg::ASCII_SPACE;
    assign o_char_unit_c      = adf_pkg::ASCII_C;
    assign o_char_unit_m      = adf_pkg::ASCII_M;

endmodule

[hw/rtl/adf_checker.sv]
// Port-level checker for the ADC distance decimal formatter and its bind.
// Checks latency, range flag, star text and decimal text; depends on adf_pkg.
module adf_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_done,
    input logic [adf_pkg::DIST_W-1:0]   o_distance_value,
    input logic                         o_overflow,
    input logic [7:0]                   o_char_units,
    input logic [7:0]                   o_char_tenths,
    input logic [7:0]                   o_char_hundredths,
    input logic [7:0]                   o_char_thousandths
);

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, adf_pkg::LATENCY))
        else $error("Result without a transaction at the expected latency.");

    a_ovf_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_overflow == (o_distance_value > adf_pkg::DISPLAY_MAX)))
        else $error("Overflow flag disagrees with the distance.");

    a_ovf_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_overflow) |-> (o_char_units == adf_pkg::ASCII_STAR &&
                                    o_char_tenths == adf_pkg::ASCII_STAR &&
                                    o_char_hundredths == adf_pkg::ASCII_STAR &&
                                    o_char_thousandths == adf_pkg::ASCII_STAR))
        else $error("Overflow result does not show stars.");

    a_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_overflow) |->
            (o_char_units >= adf_pkg::ASCII_ZERO && o_char_units <= adf_pkg::ASCII_NINE &&
             o_char_tenths >= adf_pkg::ASCII_ZERO && o_char_tenths <= adf_pkg::ASCII_NINE &&
             o_char_hundredths >= adf_pkg::ASCII_ZERO &&
             o_char_hundredths <= adf_pkg::ASCII_NINE &&
             o_char_thousandths >= adf_pkg::ASCII_ZERO &&
             o_char_thousandths <= adf_pkg::ASCII_NINE &&
             (32'(o_char_units - adf_pkg::ASCII_ZERO) * 32'd1000 +
              32'(o_char_tenths - adf_pkg::ASCII_ZERO) * 32'd100 +
              32'(o_char_hundredths - adf_pkg::ASCII_ZERO) * 32'd10 +
              32'(o_char_thousandths - adf_pkg::ASCII_ZERO)) == 32'(o_distance_value)))
        else $error("Decimal text does not match the distance.");

endmodule

bind adc_distance_decimal_formatter_core adf_checker u_adf_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .o_done             (o_done),
    .o_distance_value   (o_distance_value),
    .o_overflow         (o_overflow),
    .o_char_units       (o_char_units),
    .o_char_tenths      (o_char_tenths),
    .o_char_hundredths  (o_char_hundredths),
    .o_char_thousandths (o_char_thousandths)
);

[sim/adc_distance_decimal_formatter_checker.sv]
`timescale 1ns / 100ps
// Checker for the ADC distance decimal formatter: it mirrors the calibration registers,
// predicts every reading from the accepted samples and compares it with the result port.
// Depends on adf_pkg for widths, register indexes and ASCII codes.
module adc_distance_decimal_formatter_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic [adf_pkg::SAMPLE_W-1:0] i_adc_sample,
    input  logic                         i_cfg_we,
    input  logic [adf_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [adf_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_done,
    input  logic [adf_pkg::DIST_W-1:0]   i_distance_value,
    input  logic                         i_overflow,
    input  logic [7:0]                   i_char_units,
    input  logic [7:0]                   i_char_point,
    input  logic [7:0]                   i_char_tenths,
    input  logic [7:0]                   i_char_hundredths,
    input  logic [7:0]                   i_char_thousandths,
    input  logic [7:0]                   i_char_space,
    input  logic [7:0]                   i_char_unit_c,
    input  logic [7:0]                   i_char_unit_m,
    output int                           o_error_count,
    output int                           o_pending,
    output int                           o_reading_count,
    output int                           o_overflow_count
);

    typedef struct packed {
        logic [adf_pkg::DIST_W-1:0] distance;
        logic                       overflow;
        logic [7:0]                 units;
        logic [7:0]                 point;
        logic [7:0]                 tenths;
        logic [7:0]                 hundredths;
        logic [7:0]                 thousandths;
        logic [7:0]                 space;
        logic [7:0]                 unit_c;
        logic [7:0]                 unit_m;
    } t_reading;

    logic [adf_pkg::SAMPLE_W-1:0] offset_q;
    logic [adf_pkg::NUM_W-1:0]    numerator_q;
    logic [adf_pkg::DEN_W-1:0]    denominator_q;

    t_reading pending_readings[$];
    t_reading want;
    int       error_count   = 0;
    int       reading_count = 0;
    int       star_count    = 0;

    function automatic t_reading format_distance(input logic [adf_pkg::SAMPLE_W-1:0] sample);
        t_reading                   r;
        logic [adf_pkg::SUM_W-1:0]  sum;
        logic [adf_pkg::DIST_W-1:0] product;
        logic [adf_pkg::DIST_W-1:0] v;
        logic [7:0]                 digit [4];
        sum     = adf_pkg::SUM_W'(sample) + adf_pkg::SUM_W'(offset_q);
        product = adf_pkg::DIST_W'(sum) * adf_pkg::DIST_W'(numerator_q);
        if (denominator_q == '0) begin
            r.distance = {adf_pkg::DIST_W{1'b1}};
        end else begin
            r.distance = product / adf_pkg::DIST_W'(denominator_q);
        end
        r.overflow = (r.distance > adf_pkg::DISPLAY_MAX);
        v = r.distance;
        for (int i = 3; i >= 0; i--) begin
            digit[i] = r.overflow ? adf_pkg::ASCII_STAR
                                  : adf_pkg::ASCII_ZERO + 8'(v % adf_pkg::DIST_W'(10));
            v = v / adf_pkg::DIST_W'(10);
        end
        r.units       = digit[0];
        r.point       = adf_pkg::ASCII_POINT;
        r.tenths      = digit[1];
        r.hundredths  = digit[2];
        r.thousandths = digit[3];
        r.space       = adf_pkg::ASCII_SPACE;
        r.unit_c      = adf_pkg::ASCII_C;
        r.unit_m      = adf_pkg::ASCII_M;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            error_count++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            offset_q      = adf_pkg::RST_SAMPLE_OFFSET;
            numerator_q   = adf_pkg::RST_SCALE_NUMERATOR;
            denominator_q = adf_pkg::RST_SCALE_DENOMINATOR;
            pending_readings.delete();
        end else begin
            if (i_done) begin
                if (pending_readings.size() == 0) begin
                    error_count++;
                    $display("%0t ns: unexpected result transaction, distance 0x%0h",
                             $time, i_distance_value);
                end else begin
                    want = pending_readings.pop_front();
                    reading_count++;
                    if (want.overflow) star_count++;
                    check_field("distance_value", 32'(want.distance), 32'(i_distance_value));
                    check_field("overflow", 32'(want.overflow), 32'(i_overflow));
                    check_field("char_units", 32'(want.units), 32'(i_char_units));
                    check_field("char_point", 32'(want.point), 32'(i_char_point));
                    check_field("char_tenths", 32'(want.tenths), 32'(i_char_tenths));
                    check_field("char_hundredths", 32'(want.hundredths),
                                32'(i_char_hundredths));
                    check_field("char_thousandths", 32'(want.thousandths),
                                32'(i_char_thousandths));
                    check_field("char_space", 32'(want.space), 32'(i_char_space));
                    check_field("char_unit_c", 32'(want.unit_c), 32'(i_char_unit_c));
                    check_field("char_unit_m", 32'(want.unit_m), 32'(i_char_unit_m));
                end
            end
            if (i_start && !i_busy) begin
                pending_readings.push_back(format_distance(i_adc_sample));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    adf_pkg::REG_SAMPLE_OFFSET:
                        offset_q = i_cfg_data[adf_pkg::SAMPLE_W-1:0];
                    adf_pkg::REG_SCALE_NUMERATOR:
                        numerator_q = i_cfg_data[adf_pkg::NUM_W-1:0];
                    adf_pkg::REG_SCALE_DENOMINATOR:
                        denominator_q = i_cfg_data[adf_pkg::DEN_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending        <= pending_readings.size();
        o_error_count    <= error_count;
        o_reading_count  <= reading_count;
        o_overflow_count <= star_count;
    end

endmodule

[sim/tb_adc_distance_decimal_formatter_core.sv]
`timescale 1ns / 100ps
// Testbench top for adc_distance_decimal_formatter_core: drives samples and register
// writes, and reports the verdict. Depends on adf_pkg and the formatter checker.
module tb_adc_distance_decimal_formatter_core;

    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 200;

    localparam logic [adf_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                         i_clk              = 1'b0;
    logic                         i_rst_n            = 1'b0;
    logic                         start              = 1'b0;
    logic                         busy;
    logic [adf_pkg::SAMPLE_W-1:0] i_adc_sample       = '0;
    logic                         i_cfg_we           = 1'b0;
    logic [adf_pkg::IDX_W-1:0]    i_cfg_idx          = '0;
    logic [adf_pkg::CFG_W-1:0]    i_cfg_data         = '0;
    logic                         o_done;
    logic [adf_pkg::DIST_W-1:0]   o_distance_value;
    logic                         o_overflow;
    logic [7:0]                   o_char_units;
    logic [7:0]                   o_char_point;
    logic [7:0]                   o_char_tenths;
    logic [7:0]                   o_char_hundredths;
    logic [7:0]                   o_char_thousandths;
    logic [7:0]                   o_char_space;
    logic [7:0]                   o_char_unit_c;
    logic [7:0]                   o_char_unit_m;

    int error_count;
    int pending;
    int reading_count;
    int overflow_count;
    int setting_count = 0;
    bit idle_enable   = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    adc_distance_decimal_formatter_core u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_adc_sample       (i_adc_sample),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .o_done             (o_done),
        .o_distance_value   (o_distance_value),
        .o_overflow         (o_overflow),
        .o_char_units       (o_char_units),
        .o_char_point       (o_char_point),
        .o_char_tenths      (o_char_tenths),
        .o_char_hundredths  (o_char_hundredths),
        .o_char_thousandths (o_char_thousandths),
        .o_char_space       (o_char_space),
        .o_char_unit_c      (o_char_unit_c),
        .o_char_unit_m      (o_char_unit_m)
    );

    adc_distance_decimal_formatter_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_busy             (busy),
        .i_adc_sample       (i_adc_sample),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_done             (o_done),
        .i_distance_value   (o_distance_value),
        .i_overflow         (o_overflow),
        .i_char_units       (o_char_units),
        .i_char_point       (o_char_point),
        .i_char_tenths      (o_char_tenths),
        .i_char_hundredths  (o_char_hundredths),
        .i_char_thousandths (o_char_thousandths),
        .i_char_space       (o_char_space),
        .i_char_unit_c      (o_char_unit_c),
        .i_char_unit_m      (o_char_unit_m),
        .o_error_count      (error_count),
        .o_pending          (pending),
        .o_reading_count    (reading_count),
        .o_overflow_count   (overflow_count)
    );

    task automatic send_sample(input logic [adf_pkg::SAMPLE_W-1:0] sample);
        while (idle_enable && $urandom_range(99) < 7) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_adc_sample <= sample;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain_readings();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [adf_pkg::IDX_W-1:0] idx,
                             input logic [adf_pkg::CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic program_scale(input logic [adf_pkg::CFG_W-1:0] offset,
                                 input logic [adf_pkg::CFG_W-1:0] numerator,
                                 input logic [adf_pkg::CFG_W-1:0] denominator);
        drain_readings();
        write_reg(REG_UNUSED, adf_pkg::CFG_W'($urandom));
        write_reg(adf_pkg::REG_SAMPLE_OFFSET, offset);
        write_reg(adf_pkg::REG_SCALE_NUMERATOR, numerator);
        write_reg(adf_pkg::REG_SCALE_DENOMINATOR, denominator);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        setting_count++;
    endtask

    task automatic pick_random_scale(input int mode);
        int offset;
        int numerator;
        int denominator;
        int top_sum;
        case (mode)
            0: begin
                offset      = $urandom_range(65535);
                numerator   = $urandom_range(65535);
                denominator = $urandom_range(65535);
            end
            1: begin
                offset      = $urandom_range(65535);
                top_sum     = (offset & 12'hFFF) + 4095;
                numerator   = $urandom_range(60000, 1);
                denominator = (top_sum * numerator) / $urandom_range(14000, 8000) + 1;
            end
            2: begin
                offset      = int'(adf_pkg::RST_SAMPLE_OFFSET);
                numerator   = int'(adf_pkg::RST_SCALE_NUMERATOR);
                denominator = int'(adf_pkg::RST_SCALE_DENOMINATOR);
            end
            default: begin
                offset      = $urandom_range(1) ? 65535 : 0;
                numerator   = ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? 1 : 65535);
                denominator = ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? 1 : 65535);
            end
        endcase
        program_scale(adf_pkg::CFG_W'(offset), adf_pkg::CFG_W'(numerator),
                      adf_pkg::CFG_W'(denominator));
    endtask

    initial begin
        #2_000_000;
        $display("[adc_distance_decimal_formatter_core] ERROR");
        $finish;
    end

    initial begin
        logic [adf_pkg::SAMPLE_W-1:0] sample;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd1);
        send_sample(12'd2048);
        send_sample(12'hAAA);
        send_sample(12'h555);

        program_scale(16'hFFFF, 16'hFFFF, 16'd1);
        send_sample(12'd4095);
        send_sample(12'd0);

        program_scale(16'h0000, 16'd1000, 16'd0);
        send_sample(12'd0);
        send_sample(12'd4095);

        program_scale(16'hF123, 16'd0, 16'hFFFF);
        send_sample(12'd4095);
        send_sample(12'd7);

        program_scale(16'd0, 16'd9999, 16'd1);
        send_sample(12'd0);
        send_sample(12'd1);
        send_sample(12'd2);

        program_scale(16'd0, 16'd1234, 16'd4095);
        send_sample(12'd4095);
        send_sample(adf_pkg::SAMPLE_W'($urandom));

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            pick_random_scale(phase % 4);
            idle_enable = (phase != 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 1 && n == PHASE_ITEMS / 2) drain_readings();
                case ($urandom_range(9))
                    0:       sample = '0;
                    1:       sample = '1;
                    default: sample = adf_pkg::SAMPLE_W'($urandom);
                endcase
                send_sample(sample);
            end
        end

        drain_readings();
        repeat (adf_pkg::LATENCY + 8) @(posedge i_clk);
        $display("Checked %0d readings, %0d of them on the star display, over %0d settings.",
                 reading_count, overflow_count, setting_count + 1);
        if (error_count == 0) begin
            $display("[adc_distance_decimal_formatter_core] OK");
        end else begin
            $display("[adc_distance_decimal_formatter_core] ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/adf_pkg.sv
hw/rtl/adf_scale.sv
hw/rtl/adf_divider.sv
hw/rtl/adf_bcd.sv
hw/rtl/adc_distance_decimal_formatter_core.sv
hw/rtl/adf_checker.sv
sim/adc_distance_decimal_formatter_checker.sv
sim/tb_adc_distance_decimal_formatter_core.sv
